// File: hw/rtl/iac_pkg.sv
// ----------------------------------------------------------------------------
// iac_pkg: shared types and constants of the attitude filter
// Widths, register indexes, sequencer states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package iac_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int ANG_W      = 27;
    // Accelerometer angle: up to 180 degrees with at most 20 fraction bits.
    localparam int ACC_W      = 29;
    // Multiplier operand: accelerometer angle minus stored angle.
    localparam int MUL_A_W    = 30;
    // CORDIC vector and angle accumulator.
    localparam int CORDIC_W   = 36;
    localparam int Z_W        = 36;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_W     = 30;
    localparam int IDX_W      = 5;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     GYRO_GAIN_RST    = 16'd10230;
    localparam logic [CFG_W-1:0]     ACCEL_WEIGHT_RST = 16'd1311;

    // 180 degrees with 24 fraction bits.
    localparam logic signed [Z_W-1:0] DEG180_Q24 = 36'sd3019898880;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CP_GO,
        S_CP_WAIT,
        S_CR_GO,
        S_CR_WAIT,
        S_MAC_GO,
        S_MAC_W1,
        S_MAC_W2,
        S_OUT
    } t_state;

    // Multiply-accumulate operations, issued in this order.
    typedef enum logic [2:0] {
        OP_GYRO_P,
        OP_GYRO_R,
        OP_GYRO_Y,
        OP_BLEND_P,
        OP_BLEND_R
    } t_op;

    // CORDIC status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // Control of one multiply-accumulate operation.
    typedef struct packed {
        logic sub;
        logic blend;
    } t_mac_op;

    // atan(2^-i) in degrees with 24 fraction bits.
    function automatic logic [ATAN_W-1:0] atan_q24(input logic [IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/iac_in_if.sv
// ----------------------------------------------------------------------------
// iac_in_if: raw six-axis sample channel
// Valid/ready channel carrying one gyro and accelerometer sample.
// ----------------------------------------------------------------------------
interface iac_in_if;
    import iac_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic signed [SAMPLE_W-1:0] acc_x;
    logic signed [SAMPLE_W-1:0] acc_y;
    logic signed [SAMPLE_W-1:0] acc_z;

    modport source (
        output valid, gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z,
        input  ready
    );

    modport sink (
        input  valid, gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z,
        output ready
    );
endinterface

// File: hw/rtl/iac_out_if.sv
// ----------------------------------------------------------------------------
// iac_out_if: attitude result channel
// Valid/ready channel carrying pitch, roll and yaw in fixed-point degrees.
// ----------------------------------------------------------------------------
interface iac_out_if;
    import iac_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] pitch_deg;
    logic signed [ANG_W-1:0] roll_deg;
    logic signed [ANG_W-1:0] yaw_deg;

    modport source (
        output valid, pitch_deg, roll_deg, yaw_deg,
        input  ready
    );

    modport sink (
        input  valid, pitch_deg, roll_deg, yaw_deg,
        output ready
    );
endinterface

// File: hw/rtl/iac_cordic.sv
// ----------------------------------------------------------------------------
// iac_cordic: iterative vectoring CORDIC for atan2
// One micro-rotation per cycle; the result is rounded to the angle format.
// ----------------------------------------------------------------------------
module iac_cordic #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [iac_pkg::SAMPLE_W-1:0]  i_num,
    input  logic signed [iac_pkg::SAMPLE_W-1:0]  i_den,
    output logic signed [iac_pkg::ACC_W-1:0]     o_angle,
    output iac_pkg::t_cordic_stat                o_stat
);
    import iac_pkg::*;

    localparam int N_ITER    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int OUT_SHIFT = 24 - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_ITER - 1);

    logic signed [CORDIC_W-1:0] r_x, n_x;
    logic signed [CORDIC_W-1:0] r_y, n_y;
    logic signed [Z_W-1:0]      r_z, n_z;
    logic [IDX_W-1:0]           r_i;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_zero;

    logic signed [CORDIC_W-1:0] w_num;
    logic signed [CORDIC_W-1:0] w_den;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [Z_W-1:0]      w_atan;
    logic signed [Z_W-1:0]      w_zr;

    // Operands scaled by 2^16.
    assign w_num = CORDIC_W'(i_num) <<< 16;
    assign w_den = CORDIC_W'(i_den) <<< 16;

    // Shared shifters and table lookup for the current micro-rotation.
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = $signed(Z_W'(atan_q24(r_i)));

    // Next vector and angle: initial quadrant fold on start, else one rotation while busy with a nonzero numerator.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_start) begin
            if (i_den < 0) begin
                n_x = -w_den;
                n_y = -w_num;
                n_z = (i_num >= 0) ? DEG180_Q24 : -DEG180_Q24;
            end else begin
                n_x = w_den;
                n_y = w_num;
                n_z = '0;
            end
            // A zero numerator gives 0 or 180 degrees without rotating.
            if (i_num == 0) begin
                n_z = (i_den < 0) ? DEG180_Q24 : '0;
            end
        end else if (r_busy && !r_zero) begin
            if (!r_y[CORDIC_W-1]) begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end else begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (i_start) begin
            r_zero <= (i_num == 0);
        end
    end

    // Iteration counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST_IDX) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Round half up to the output angle format.
    assign w_zr    = (r_z + Z_HALF) >>> OUT_SHIFT;
    assign o_angle = w_zr[ACC_W-1:0];
    assign o_stat  = '{busy: r_busy, done: r_done};

endmodule

// File: hw/rtl/iac_mac.sv
// ----------------------------------------------------------------------------
// iac_mac: shared multiply, round and saturate unit
// Computes sat(base +/- round(a * b / 2^shift)) over two registered stages.
// ----------------------------------------------------------------------------
module iac_mac #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  iac_pkg::t_mac_op                    i_op,
    input  logic signed [iac_pkg::MUL_A_W-1:0]  i_a,
    input  logic [iac_pkg::CFG_W-1:0]           i_b,
    input  logic signed [iac_pkg::ANG_W-1:0]    i_base,
    output logic signed [iac_pkg::ANG_W-1:0]    o_result,
    output logic                                o_done
);
    import iac_pkg::*;

    localparam int PROD_W      = MUL_A_W + CFG_W + 1;
    localparam int SUM_W       = 32;
    localparam int GYRO_SHIFT  = 24 - ANGLE_FRAC_BITS;
    localparam int BLEND_SHIFT = 16;
    localparam logic signed [PROD_W-1:0] G_HALF = PROD_W'(1) <<< (GYRO_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] B_HALF = PROD_W'(1) <<< (BLEND_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]  SAT_MAX = SUM_W'((64'sd1 <<< (ANG_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_MIN = -(SUM_W'(64'sd1 <<< (ANG_W - 1)));

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ANG_W-1:0]  r_base;
    t_mac_op                  r_op;
    logic                     r_valid;
    logic signed [ANG_W-1:0]  r_result;
    logic                     r_done;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rs_g;
    logic signed [PROD_W-1:0] w_rs_b;
    logic signed [SUM_W-1:0]  w_rs;
    logic signed [SUM_W-1:0]  w_base;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [ANG_W-1:0]  w_sat;

    // Stage one: the multiplication.
    assign w_prod = PROD_W'(i_a) * PROD_W'($signed({1'b0, i_b}));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= w_prod;
            r_base <= i_base;
            r_op   <= i_op;
        end
    end

    // Stage two: round half up, add or subtract, saturate.
    assign w_rs_g = (r_prod + G_HALF) >>> GYRO_SHIFT;
    assign w_rs_b = (r_prod + B_HALF) >>> BLEND_SHIFT;
    assign w_rs   = r_op.blend ? w_rs_b[SUM_W-1:0] : w_rs_g[SUM_W-1:0];
    assign w_base = SUM_W'(r_base);
    assign w_sum  = r_op.sub ? (w_base - w_rs) : (w_base + w_rs);

    always_comb begin
        if (w_sum > SAT_MAX) begin
            w_sat = SAT_MAX[ANG_W-1:0];
        end else if (w_sum < SAT_MIN) begin
            w_sat = SAT_MIN[ANG_W-1:0];
        end else begin
            w_sat = w_sum[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_result <= w_sat;
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= i_start;
            r_done  <= r_valid;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

// File: hw/rtl/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude: complementary-filter attitude estimator
// Integrates gyro rates into pitch, roll and yaw and blends pitch and roll
// toward the accelerometer tilt angles.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one raw six-axis sample per transaction; o_out returns the
//   updated pitch, roll and yaw for every sample. The configuration port
//   writes gyro_gain (index 0) and accel_weight (index 1); the user must
//   write them only while idle, which the block itself does not enforce.
// Sequence:
//   Two atan2 evaluations on the shared CORDIC, one micro-rotation per
//   cycle, come first; the five multiply-round-saturate operations then
//   run one after another on the shared multiplier. i_in.ready is high
//   only while the block is idle, so one sample is in flight at a time:
//   a new sample is taken only after the result of the last one has been
//   taken from o_out.
// Reset:
//   Synchronous, active low. Angles clear to zero and the registers take
//   their default gains.
// Stall:
//   A result holds on o_out until it is taken; no new sample is accepted
//   in the meantime.
// ----------------------------------------------------------------------------
module imu_complementary_attitude #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    iac_in_if.sink                              i_in,
    iac_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [iac_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [iac_pkg::CFG_W-1:0]           i_cfg_data
);
    import iac_pkg::*;

    t_state r_state, n_state;
    t_op    r_op,    n_op;

    logic [CFG_W-1:0]           r_gyro_gain;
    logic [CFG_W-1:0]           r_accel_weight;
    logic signed [ANG_W-1:0]    r_pitch;
    logic signed [ANG_W-1:0]    r_roll;
    logic signed [ANG_W-1:0]    r_yaw;
    logic signed [ACC_W-1:0]    r_acc_p;
    logic signed [ACC_W-1:0]    r_acc_r;
    logic signed [SAMPLE_W-1:0] r_gx;
    logic signed [SAMPLE_W-1:0] r_gy;
    logic signed [SAMPLE_W-1:0] r_gz;
    logic signed [SAMPLE_W-1:0] r_ax;
    logic signed [SAMPLE_W-1:0] r_ay;
    logic signed [SAMPLE_W-1:0] r_az;

    logic                       w_in_ready;
    logic                       w_out_valid;
    logic                       w_cordic_start;
    logic                       w_mac_start;
    logic                       w_accept;
    logic                       w_out_done;
    logic signed [SAMPLE_W-1:0] w_cordic_num;
    logic signed [ACC_W-1:0]    w_cordic_angle;
    t_cordic_stat               w_cordic_stat;
    t_mac_op                    w_mac_op;
    logic signed [MUL_A_W-1:0]  w_mac_a;
    logic [CFG_W-1:0]           w_mac_b;
    logic signed [ANG_W-1:0]    w_mac_base;
    logic signed [ANG_W-1:0]    w_mac_result;
    logic                       w_mac_done;

    assign w_accept   = i_in.valid && w_in_ready;
    assign w_out_done = w_out_valid && o_out.ready;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_accept) n_state = S_CP_GO;
            S_CP_GO:   n_state = S_CP_WAIT;
            S_CP_WAIT: if (w_cordic_stat.done) n_state = S_CR_GO;
            S_CR_GO:   n_state = S_CR_WAIT;
            S_CR_WAIT: if (w_cordic_stat.done) n_state = S_MAC_GO;
            S_MAC_GO:  n_state = S_MAC_W1;
            S_MAC_W1:  n_state = S_MAC_W2;
            S_MAC_W2:  n_state = (r_op == OP_BLEND_R) ? S_OUT : S_MAC_GO;
            S_OUT:     if (w_out_done) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_in_ready     = 1'b0;
        w_out_valid    = 1'b0;
        w_cordic_start = 1'b0;
        w_mac_start    = 1'b0;
        case (r_state)
            S_IDLE:   w_in_ready     = 1'b1;
            S_CP_GO:  w_cordic_start = 1'b1;
            S_CR_GO:  w_cordic_start = 1'b1;
            S_MAC_GO: w_mac_start    = 1'b1;
            S_OUT:    w_out_valid    = 1'b1;
            default:  w_in_ready     = 1'b0;
        endcase
    end

    // Operation order of the multiply unit.
    always_comb begin
        case (r_op)
            OP_GYRO_P:  n_op = OP_GYRO_R;
            OP_GYRO_R:  n_op = OP_GYRO_Y;
            OP_GYRO_Y:  n_op = OP_BLEND_P;
            OP_BLEND_P: n_op = OP_BLEND_R;
            default:    n_op = OP_GYRO_P;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_GYRO_P;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_op <= OP_GYRO_P;
            end else if (r_state == S_MAC_W2) begin
                r_op <= n_op;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_gain    <= GYRO_GAIN_RST;
            r_accel_weight <= ACCEL_WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GYRO_GAIN:    r_gyro_gain    <= i_cfg_data;
                REG_ACCEL_WEIGHT: r_accel_weight <= i_cfg_data;
                default:          r_gyro_gain    <= r_gyro_gain;
            endcase
        end
    end

    // Sample capture and accelerometer angles.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gx <= i_in.gyro_x;
            r_gy <= i_in.gyro_y;
            r_gz <= i_in.gyro_z;
            r_ax <= i_in.acc_x;
            r_ay <= i_in.acc_y;
            r_az <= i_in.acc_z;
        end
        if (r_state == S_CP_WAIT && w_cordic_stat.done) begin
            r_acc_p <= w_cordic_angle;
        end
        if (r_state == S_CR_WAIT && w_cordic_stat.done) begin
            r_acc_r <= w_cordic_angle;
        end
    end

    // Angle state, written back from the multiply unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_roll  <= '0;
            r_yaw   <= '0;
        end else if (r_state == S_MAC_W2 && w_mac_done) begin
            case (r_op)
                OP_GYRO_P:  r_pitch <= w_mac_result;
                OP_GYRO_R:  r_roll  <= w_mac_result;
                OP_GYRO_Y:  r_yaw   <= w_mac_result;
                OP_BLEND_P: r_pitch <= w_mac_result;
                OP_BLEND_R: r_roll  <= w_mac_result;
                default:    r_yaw   <= r_yaw;
            endcase
        end
    end

    // Operand selection for the multiply unit.
    always_comb begin
        w_mac_op   = '{sub: 1'b0, blend: 1'b0};
        w_mac_a    = MUL_A_W'(r_gx);
        w_mac_b    = r_gyro_gain;
        w_mac_base = r_pitch;
        case (r_op)
            OP_GYRO_P: begin
                w_mac_a    = MUL_A_W'(r_gx);
                w_mac_base = r_pitch;
            end
            OP_GYRO_R: begin
                w_mac_op.sub = 1'b1;
                w_mac_a      = MUL_A_W'(r_gy);
                w_mac_base   = r_roll;
            end
            OP_GYRO_Y: begin
                w_mac_a    = MUL_A_W'(r_gz);
                w_mac_base = r_yaw;
            end
            OP_BLEND_P: begin
                // a*(1-w) + acc*w equals a + (acc - a)*w.
                w_mac_op.blend = 1'b1;
                w_mac_a        = MUL_A_W'(r_acc_p) - MUL_A_W'(r_pitch);
                w_mac_b        = r_accel_weight;
                w_mac_base     = r_pitch;
            end
            OP_BLEND_R: begin
                w_mac_op.blend = 1'b1;
                w_mac_a        = MUL_A_W'(r_acc_r) - MUL_A_W'(r_roll);
                w_mac_b        = r_accel_weight;
                w_mac_base     = r_roll;
            end
            default: begin
                w_mac_a = MUL_A_W'(r_gx);
            end
        endcase
    end

    assign w_cordic_num = (r_state == S_CR_GO) ? r_ax : r_ay;

    iac_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_num   (w_cordic_num),
        .i_den   (r_az),
        .o_angle (w_cordic_angle),
        .o_stat  (w_cordic_stat)
    );

    iac_mac #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mac_start),
        .i_op     (w_mac_op),
        .i_a      (w_mac_a),
        .i_b      (w_mac_b),
        .i_base   (w_mac_base),
        .o_result (w_mac_result),
        .o_done   (w_mac_done)
    );

    // Channel outputs.
    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = w_out_valid;
    assign o_out.pitch_deg = r_pitch;
    assign o_out.roll_deg  = r_roll;
    assign o_out.yaw_deg   = r_yaw;

endmodule

// File: hw/rtl/iac_checker.sv
// ----------------------------------------------------------------------------
// iac_checker: port-level checks of the attitude filter
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module iac_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [iac_pkg::ANG_W-1:0]  i_pitch_deg,
    input logic signed [iac_pkg::ANG_W-1:0]  i_roll_deg,
    input logic signed [iac_pkg::ANG_W-1:0]  i_yaw_deg
);
    import iac_pkg::*;

    // Only one sample is in flight: a pending result blocks new input.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result is pending");

    // An accepted sample closes the input until its result is delivered.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready after a transaction");

    // Delivering the result returns the block to idle.
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> i_in_ready)
        else $error("block not idle after result transaction");

    // A stalled result holds its angles.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pitch_deg) && $stable(i_roll_deg)
             && $stable(i_yaw_deg)))
        else $error("stalled result changed");

endmodule

bind imu_complementary_attitude iac_checker u_iac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pitch_deg (o_out.pitch_deg),
    .i_roll_deg  (o_out.roll_deg),
    .i_yaw_deg   (o_out.yaw_deg)
);
